// ----- design/sdrs_pkg.sv -----
// ----------------------------------------------------------------------------
// sdrs_pkg
// Shared widths, result status codes and cell operations for the SCAN disk
// request scheduler.
// ----------------------------------------------------------------------------
package sdrs_pkg;

  localparam int unsigned DepthDef = 64;
  localparam int unsigned TrackW   = 16;
  localparam int unsigned IdW      = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned PendW    = 7;

  localparam logic [StatusW-1:0] StatusAdded      = 2'd0;
  localparam logic [StatusW-1:0] StatusDispatched = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty      = 2'd2;
  localparam logic [StatusW-1:0] StatusFull       = 2'd3;

  localparam logic CmdAdd      = 1'b0;
  localparam logic CmdDispatch = 1'b1;

  // Operation broadcast to every cell of the request chain.
  typedef enum logic [1:0] {
    CELL_HOLD,    // keep contents
    CELL_LOAD,    // selected cell takes the new request
    CELL_ROTATE,  // every cell takes its upper neighbor, ring wraps
    CELL_CLOSE    // cells at and above the selected index take their neighbor
  } cell_op_e;

endpackage

// ----- design/sdrs_cell.sv -----
// ----------------------------------------------------------------------------
// sdrs_cell
// One slot of the request chain: holds a track and an id, loads a new
// request or takes the word of its upper neighbor.
// ----------------------------------------------------------------------------
module sdrs_cell #(
  parameter int unsigned IdxW    = 6,
  parameter int unsigned CellIdx = 0
) (
  input  logic                         clk_i,
  input  sdrs_pkg::cell_op_e           op_i,
  input  logic [IdxW-1:0]              sel_idx_i,
  input  logic [sdrs_pkg::TrackW-1:0]  new_track_i,
  input  logic [sdrs_pkg::IdW-1:0]     new_id_i,
  input  logic [sdrs_pkg::TrackW-1:0]  nbr_track_i,
  input  logic [sdrs_pkg::IdW-1:0]     nbr_id_i,
  output logic [sdrs_pkg::TrackW-1:0]  track_o,
  output logic [sdrs_pkg::IdW-1:0]     id_o
);
  import sdrs_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic [TrackW-1:0] track_q, track_d;
  logic [IdW-1:0]    id_q, id_d;

  always_comb begin
    track_d = track_q;
    id_d    = id_q;
    unique case (op_i)
      CELL_HOLD: begin
      end
      CELL_LOAD: begin
        if (sel_idx_i == MyIdx) begin
          track_d = new_track_i;
          id_d    = new_id_i;
        end
      end
      CELL_ROTATE: begin
        track_d = nbr_track_i;
        id_d    = nbr_id_i;
      end
      CELL_CLOSE: begin
        if (MyIdx >= sel_idx_i) begin
          track_d = nbr_track_i;
          id_d    = nbr_id_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    track_q <= track_d;
    id_q    <= id_d;
  end

  assign track_o = track_q;
  assign id_o    = id_q;

endmodule

// ----- design/sdrs_scan.sv -----
// ----------------------------------------------------------------------------
// sdrs_scan
// Nearest-request tracker: while enabled, takes the chain's read-point word
// one entry per cycle and keeps the nearest request above and below the head.
// ----------------------------------------------------------------------------
module sdrs_scan #(
  parameter int unsigned IdxW = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic                         en_i,
  input  logic [sdrs_pkg::TrackW-1:0]  head_i,
  input  logic [sdrs_pkg::TrackW-1:0]  track_i,
  input  logic [sdrs_pkg::IdW-1:0]     id_i,
  input  logic [IdxW-1:0]              idx_i,
  output logic                         up_found_o,
  output logic [IdxW-1:0]              up_idx_o,
  output logic [sdrs_pkg::TrackW-1:0]  up_track_o,
  output logic [sdrs_pkg::IdW-1:0]     up_id_o,
  output logic                         dn_found_o,
  output logic [IdxW-1:0]              dn_idx_o,
  output logic [sdrs_pkg::TrackW-1:0]  dn_track_o,
  output logic [sdrs_pkg::IdW-1:0]     dn_id_o
);
  import sdrs_pkg::*;

  logic              up_found_q, dn_found_q;
  logic [TrackW-1:0] up_dist_q, dn_dist_q;
  logic [IdxW-1:0]   up_idx_q, dn_idx_q;
  logic [TrackW-1:0] up_track_q, dn_track_q;
  logic [IdW-1:0]    up_id_q, dn_id_q;

  logic [TrackW-1:0] up_dist, dn_dist;
  logic              up_take, dn_take;

  // Strict compare keeps the earliest arrival on equal distance.
  always_comb begin
    up_dist = track_i - head_i;
    dn_dist = head_i - track_i;
    up_take = en_i && (track_i >= head_i) && (!up_found_q || (up_dist < up_dist_q));
    dn_take = en_i && (track_i <= head_i) && (!dn_found_q || (dn_dist < dn_dist_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_found_q <= 1'b0;
      dn_found_q <= 1'b0;
    end else if (clear_i) begin
      up_found_q <= 1'b0;
      dn_found_q <= 1'b0;
    end else begin
      if (up_take) up_found_q <= 1'b1;
      if (dn_take) dn_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_take) begin
      up_dist_q  <= up_dist;
      up_idx_q   <= idx_i;
      up_track_q <= track_i;
      up_id_q    <= id_i;
    end
    if (dn_take) begin
      dn_dist_q  <= dn_dist;
      dn_idx_q   <= idx_i;
      dn_track_q <= track_i;
      dn_id_q    <= id_i;
    end
  end

  assign up_found_o = up_found_q;
  assign up_idx_o   = up_idx_q;
  assign up_track_o = up_track_q;
  assign up_id_o    = up_id_q;
  assign dn_found_o = dn_found_q;
  assign dn_idx_o   = dn_idx_q;
  assign dn_track_o = dn_track_q;
  assign dn_id_o    = dn_id_q;

endmodule

// ----- design/scan_disk_request_scheduler.sv -----
// ----------------------------------------------------------------------------
// scan_disk_request_scheduler
// SCAN (elevator) scheduler for up to DEPTH pending disk requests.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a command word by raising start_i while busy_o is low; the word is
//   taken at that clock edge. cmd_i selects add (track_i, req_id_i) or
//   dispatch (head_track_i). Every command yields exactly one result word,
//   shown for one cycle with done_o high: status_o, chosen_id_o,
//   chosen_track_o, moving_up_o and pending_count_o.
//   Timing: add, add-when-full and dispatch-when-empty report in the cycle
//   after acceptance, and busy_o never rises for them. A dispatch with
//   requests pending rotates the request chain once past the comparator,
//   one entry per cycle, then drops the chosen entry; busy_o stays high
//   through the pass and the drop, so no new command is taken before the
//   dispatch reports; the single scan unit sits at the chain's read point.
//   Reset empties the queue and sets the sweep direction to up; stored
//   requests are not cleared, no clearing pass is needed.
//   The receiver cannot stall: a result word is valid only in its cycle.
//   A new command may be issued in the same cycle that done_o is high.
// ----------------------------------------------------------------------------
module scan_disk_request_scheduler #(
  parameter int unsigned DEPTH = sdrs_pkg::DepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cmd_i,
  input  logic [sdrs_pkg::TrackW-1:0]   track_i,
  input  logic [sdrs_pkg::IdW-1:0]      req_id_i,
  input  logic [sdrs_pkg::TrackW-1:0]   head_track_i,
  output logic                          done_o,
  output logic [sdrs_pkg::StatusW-1:0]  status_o,
  output logic [sdrs_pkg::IdW-1:0]      chosen_id_o,
  output logic [sdrs_pkg::TrackW-1:0]   chosen_track_o,
  output logic                          moving_up_o,
  output logic [sdrs_pkg::PendW-1:0]    pending_count_o
);
  import sdrs_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   occ_q, occ_d;
  logic              dir_up_q, dir_up_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic [TrackW-1:0] head_q, head_d;

  // result word
  logic               done_q, done_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [IdW-1:0]     cid_q, cid_d;
  logic [TrackW-1:0]  ctrk_q, ctrk_d;

  // chain control
  cell_op_e        cell_op;
  logic [IdxW-1:0] cell_sel;

  logic [TrackW-1:0] cell_track [DEPTH];
  logic [IdW-1:0]    cell_id    [DEPTH];

  // scan unit
  logic              scan_clear, scan_en;
  logic              up_found, dn_found;
  logic [IdxW-1:0]   up_idx, dn_idx;
  logic [TrackW-1:0] up_track, dn_track;
  logic [IdW-1:0]    up_id, dn_id;

  logic            accept;
  logic            pick_up;
  logic [IdxW-1:0] pick_idx;

  assign accept = start_i && (state_q == StIdle);

  // Request chain: cell i feeds from cell i+1, the top cell from cell 0 so a
  // rotation pass walks every entry past cell 0 and returns to its order.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    sdrs_cell #(
      .IdxW    (IdxW),
      .CellIdx (gi)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .sel_idx_i   (cell_sel),
      .new_track_i (track_i),
      .new_id_i    (req_id_i),
      .nbr_track_i (cell_track[(gi + 1) % DEPTH]),
      .nbr_id_i    (cell_id[(gi + 1) % DEPTH]),
      .track_o     (cell_track[gi]),
      .id_o        (cell_id[gi])
    );
  end

  // Only entries below the occupancy take part in the search.
  assign scan_en = (state_q == StScan) && (CntW'(cnt_q) < occ_q);

  sdrs_scan #(
    .IdxW (IdxW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (scan_clear),
    .en_i       (scan_en),
    .head_i     (head_q),
    .track_i    (cell_track[0]),
    .id_i       (cell_id[0]),
    .idx_i      (cnt_q),
    .up_found_o (up_found),
    .up_idx_o   (up_idx),
    .up_track_o (up_track),
    .up_id_o    (up_id),
    .dn_found_o (dn_found),
    .dn_idx_o   (dn_idx),
    .dn_track_o (dn_track),
    .dn_id_o    (dn_id)
  );

  // Stay on the sweep side if it holds a request, otherwise reverse.
  assign pick_up = dir_up_q ? up_found : !dn_found;

  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    dir_up_d   = dir_up_q;
    cnt_d      = cnt_q;
    head_d     = head_q;
    done_d     = 1'b0;
    status_d   = status_q;
    cid_d      = cid_q;
    ctrk_d     = ctrk_q;
    cell_op    = CELL_HOLD;
    cell_sel   = occ_q[IdxW-1:0];
    scan_clear = 1'b0;
    pick_idx   = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          done_d = 1'b1;
          cid_d  = '0;
          ctrk_d = '0;
          if (cmd_i == CmdAdd) begin
            if (occ_q >= DepthCnt) begin
              status_d = StatusFull;
            end else begin
              // append at the tail
              cell_op  = CELL_LOAD;
              cell_sel = occ_q[IdxW-1:0];
              occ_d    = occ_q + 1'b1;
              status_d = StatusAdded;
            end
          end else if (occ_q == '0) begin
            status_d = StatusEmpty;
          end else begin
            // hold the result back until the pass completes
            done_d     = 1'b0;
            head_d     = head_track_i;
            cnt_d      = '0;
            scan_clear = 1'b1;
            state_d    = StScan;
          end
        end
      end
      StScan: begin
        cell_op = CELL_ROTATE;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (occ_q == CntW'(1)) begin
          // lone request: take it, leave the direction alone
          pick_idx = '0;
          cid_d    = cell_id[0];
          ctrk_d   = cell_track[0];
        end else begin
          dir_up_d = pick_up;
          pick_idx = pick_up ? up_idx : dn_idx;
          cid_d    = pick_up ? up_id : dn_id;
          ctrk_d   = pick_up ? up_track : dn_track;
        end
        // drop the chosen entry, close the gap
        cell_op  = CELL_CLOSE;
        cell_sel = pick_idx;
        occ_d    = occ_q - 1'b1;
        status_d = StatusDispatched;
        done_d   = 1'b1;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      occ_q    <= '0;
      dir_up_q <= 1'b1;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      dir_up_q <= dir_up_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q   <= head_d;
    status_q <= status_d;
    cid_q    <= cid_d;
    ctrk_q   <= ctrk_d;
  end

  assign busy_o          = (state_q != StIdle);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign chosen_id_o     = cid_q;
  assign chosen_track_o  = ctrk_q;
  assign moving_up_o     = dir_up_q;
  assign pending_count_o = PendW'(occ_q);

endmodule

// ----- tb/sdrs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrs_checker
// Scoreboard for the SCAN disk request scheduler: watches the command and
// result channels, keeps its own copy of the pending requests and the sweep
// direction, and compares every result word with the predicted one.
// ----------------------------------------------------------------------------
module sdrs_checker #(
  parameter int unsigned DEPTH = sdrs_pkg::DepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_o,
  input  logic                         cmd_i,
  input  logic [sdrs_pkg::TrackW-1:0]  track_i,
  input  logic [sdrs_pkg::IdW-1:0]     req_id_i,
  input  logic [sdrs_pkg::TrackW-1:0]  head_track_i,
  input  logic                         done_o,
  input  logic [sdrs_pkg::StatusW-1:0] status_o,
  input  logic [sdrs_pkg::IdW-1:0]     chosen_id_o,
  input  logic [sdrs_pkg::TrackW-1:0]  chosen_track_o,
  input  logic                         moving_up_o,
  input  logic [sdrs_pkg::PendW-1:0]   pending_count_o,
  output int                           mismatch_cnt_o,
  output int                           waiting_o
);
  import sdrs_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     id;
    logic [TrackW-1:0]  trk;
    logic               up;
    logic [PendW-1:0]   pend;
  } sched_word_t;

  logic [TrackW-1:0] queued_track [DEPTH];
  logic [IdW-1:0]    queued_id    [DEPTH];
  int unsigned       queued_cnt;
  logic              sweep_up;
  sched_word_t       expected_words [$];
  int                mismatches;

  // Nearest pending request on one side of the head, earliest on a tie.
  function automatic int find_nearest(logic [TrackW-1:0] head, logic up);
    int best;
    int best_dist;
    int d;
    best = -1;
    best_dist = 0;
    for (int i = 0; i < int'(queued_cnt); i++) begin
      if (up) begin
        if (queued_track[i] < head) continue;
        d = int'(queued_track[i]) - int'(head);
      end else begin
        if (queued_track[i] > head) continue;
        d = int'(head) - int'(queued_track[i]);
      end
      if (best < 0 || d < best_dist) begin
        best = i;
        best_dist = d;
      end
    end
    return best;
  endfunction

  // Apply one command word to the shadow queue and return its result word.
  function automatic sched_word_t schedule_step(logic cmd, logic [TrackW-1:0] trk,
                                                logic [IdW-1:0] id,
                                                logic [TrackW-1:0] head);
    sched_word_t w;
    int pick;
    w = '0;
    if (cmd == CmdAdd) begin
      if (queued_cnt >= DEPTH) begin
        w.status = StatusFull;
      end else begin
        queued_track[queued_cnt] = trk;
        queued_id[queued_cnt]    = id;
        queued_cnt++;
        w.status = StatusAdded;
      end
    end else if (queued_cnt == 0) begin
      w.status = StatusEmpty;
    end else begin
      if (queued_cnt == 1) begin
        pick = 0;
      end else begin
        pick = find_nearest(head, sweep_up);
        if (pick < 0) begin
          sweep_up = !sweep_up;
          pick = find_nearest(head, sweep_up);
        end
        if (pick < 0) pick = 0;
      end
      w.id  = queued_id[pick];
      w.trk = queued_track[pick];
      for (int i = pick; i + 1 < int'(queued_cnt); i++) begin
        queued_track[i] = queued_track[i+1];
        queued_id[i]    = queued_id[i+1];
      end
      queued_cnt--;
      w.status = StatusDispatched;
    end
    w.up   = sweep_up;
    w.pend = PendW'(queued_cnt);
    return w;
  endfunction

  task automatic note_mismatch(bit have_want, sched_word_t want, sched_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_want)
        $display("mismatch: exp st=%0d id=%h trk=%h up=%0d pend=%0d",
                 want.status, want.id, want.trk, want.up, want.pend,
                 " | got st=%0d id=%h trk=%h up=%0d pend=%0d",
                 got.status, got.id, got.trk, got.up, got.pend);
      else
        $display("mismatch: unexpected result word st=%0d id=%h trk=%h up=%0d pend=%0d",
                 got.status, got.id, got.trk, got.up, got.pend);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sched_word_t got;
    sched_word_t want;
    if (!rst_ni) begin
      queued_cnt = 0;
      sweep_up   = 1'b1;
      mismatches = 0;
      expected_words.delete();
    end else begin
      // Retire the result first: a word accepted at this edge reports later.
      if (done_o) begin
        got = {status_o, chosen_id_o, chosen_track_o, moving_up_o, pending_count_o};
        if (expected_words.size() == 0) begin
          note_mismatch(1'b0, '0, got);
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (got.status !== want.status || got.id !== want.id || got.trk !== want.trk ||
              got.up !== want.up || got.pend !== want.pend)
            note_mismatch(1'b1, want, got);
        end
      end
      if (start_i && !busy_o)
        expected_words.insert(expected_words.size(),
                              schedule_step(cmd_i, track_i, req_id_i, head_track_i));
    end
    mismatch_cnt_o = mismatches;
    waiting_o      = expected_words.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the SCAN disk request scheduler: a directed opener
// over the corner cases, then random add/dispatch bursts with random sender
// gaps; the checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import sdrs_pkg::*;

  localparam int unsigned DEPTH     = DepthDef;
  localparam int          RandItems = 1650;
  // Longest correct stretch without a handshake is one dispatch's busy pass
  // plus the largest sender gap; allow many times that.
  localparam int          IdleLimit = 20 * (DEPTH + 10);

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                cmd_i;
  logic [TrackW-1:0]   track_i;
  logic [IdW-1:0]      req_id_i;
  logic [TrackW-1:0]   head_track_i;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [IdW-1:0]      chosen_id_o;
  logic [TrackW-1:0]   chosen_track_o;
  logic                moving_up_o;
  logic [PendW-1:0]    pending_count_o;
  int                  mismatch_cnt;
  int                  words_waiting;
  int                  idle_cycles;

  scan_disk_request_scheduler #(.DEPTH(DEPTH)) u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .track_i, .req_id_i, .head_track_i,
    .done_o, .status_o, .chosen_id_o, .chosen_track_o, .moving_up_o, .pending_count_o
  );

  sdrs_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .track_i, .req_id_i, .head_track_i,
    .done_o, .status_o, .chosen_id_o, .chosen_track_o, .moving_up_o, .pending_count_o,
    .mismatch_cnt_o(mismatch_cnt), .waiting_o(words_waiting)
  );

  // 2 ns clock.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Issue one command word at the falling edge and hold it until taken.
  // Drop start only when a gap is wanted, so a back-to-back word never sees
  // start lowered and raised in the same step.
  task automatic send_word(input logic cmd, input logic [TrackW-1:0] trk,
                           input logic [IdW-1:0] id, input logic [TrackW-1:0] head,
                           input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    cmd_i        <= cmd;
    track_i      <= trk;
    req_id_i     <= id;
    head_track_i <= head;
    // Busy is sampled before the edge updates it, so this edge is the one
    // that took the word.
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Track value by style: full range, a narrow cluster (ties, head on a
  // track), or the extremes of the field.
  function automatic logic [TrackW-1:0] pick_track(int style, int base);
    case (style)
      0:       return TrackW'($urandom_range(0, 65535));
      1:       return TrackW'(base + $urandom_range(0, 7));
      default: begin
        case ($urandom_range(0, 3))
          0:       return TrackW'(0);
          1:       return TrackW'(1);
          2:       return TrackW'(65534);
          default: return TrackW'(65535);
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    int  sent;
    int  mode;
    int  tstyle;
    int  base;
    int  burst;
    int  add_pct;
    bit  quiet;
    logic cmd;
    logic [TrackW-1:0] head;

    // Known values on every input from time zero.
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    cmd_i        = CmdAdd;
    track_i      = '0;
    req_id_i     = '0;
    head_track_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opener.
    send_word(CmdDispatch, 16'h1234, 16'h5678, 16'h0000, 0);          // dispatch on empty
    send_word(CmdAdd,      16'h0000, 16'h0000, 16'hFFFF, 0);          // lowest track and id
    send_word(CmdDispatch, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2);          // lone request, below head
    send_word(CmdAdd,      16'hFFFF, 16'hFFFF, 16'h0000, 0);          // highest track and id
    send_word(CmdAdd,      16'd100,  16'd1,    16'h0000, 1);
    send_word(CmdAdd,      16'd100,  16'd2,    16'h0000, 0);          // same track: tie
    send_word(CmdAdd,      16'd50,   16'd3,    16'h0000, 0);
    send_word(CmdDispatch, 16'h0000, 16'h0000, 16'd100,  0);          // tie, earliest wins
    send_word(CmdDispatch, 16'h0000, 16'h0000, 16'd100,  3);          // head on a track
    send_word(CmdDispatch, 16'h0000, 16'h0000, 16'hFFFF, 0);          // head at top
    send_word(CmdAdd,      16'd10,   16'd4,    16'h0000, 0);
    send_word(CmdDispatch, 16'h0000, 16'h0000, 16'd60,   0);          // nothing above: flip down
    send_word(CmdDispatch, 16'h0000, 16'h0000, 16'hFFFF, 0);          // lone request, dir held
    send_word(CmdAdd,      16'd20,   16'd5,    16'h0000, 0);
    send_word(CmdAdd,      16'd20,   16'd6,    16'h0000, 0);
    send_word(CmdAdd,      16'd40,   16'd7,    16'h0000, 0);
    send_word(CmdDispatch, 16'h0000, 16'h0000, 16'd30,   0);          // down tie at 20
    send_word(CmdDispatch, 16'h0000, 16'h0000, 16'h0000, 0);          // nothing below: flip up
    send_word(CmdDispatch, 16'h0000, 16'h0000, 16'h0000, 5);          // head at bottom
    send_word(CmdDispatch, 16'hAAAA, 16'h5555, 16'h8000, 0);          // empty again
    sent = 20;

    // Random bursts: fill to full, drain to empty, and mixed sweeps.
    while (sent < 20 + RandItems) begin
      mode    = $urandom_range(0, 5);
      tstyle  = $urandom_range(0, 2);
      base    = $urandom_range(0, 65528);
      quiet   = ($urandom_range(0, 3) == 0);
      add_pct = $urandom_range(30, 70);
      case (mode)
        0:       burst = $urandom_range(60, 72);
        1:       burst = $urandom_range(10, 70);
        default: burst = $urandom_range(10, 40);
      endcase
      for (int k = 0; k < burst; k++) begin
        case (mode)
          0:       cmd = ($urandom_range(0, 99) < 95) ? CmdAdd : CmdDispatch;
          1:       cmd = ($urandom_range(0, 99) < 10) ? CmdAdd : CmdDispatch;
          default: cmd = ($urandom_range(0, 99) < add_pct) ? CmdAdd : CmdDispatch;
        endcase
        // Keep the head near the stored tracks most of the time.
        head = ($urandom_range(0, 3) == 0) ? TrackW'($urandom_range(0, 65535))
                                           : pick_track(tstyle, base);
        send_word(cmd, pick_track(tstyle, base), IdW'($urandom_range(0, 65535)), head,
                  quiet ? 0 : $urandom_range(0, 7));
        sent++;
      end
    end

    // Drain: idle the sender, wait out every expected word, then a margin.
    start_i <= 1'b0;
    while (words_waiting != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);
    if (mismatch_cnt == 0 && words_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
